// File: rtl/vgmcsp_pkg.sv
// Package for the VGM command stream parser: item structs, command codes,
// parse phases, result kinds and queue sizing.
// No dependencies; every other file in rtl/ imports it.
package vgmcsp_pkg;

  // Input item: op selects stream byte or start of a new track
  typedef struct packed {
    logic       op;
    logic [7:0] stream_byte;
  } cmd_item_t;

  // Result item
  typedef struct packed {
    logic [1:0]  kind;
    logic        chip_select;
    logic [7:0]  reg_addr;
    logic [7:0]  reg_data;
    logic [15:0] wait_samples;
    logic [25:0] wait_ticks;
    logic        fade_request;
    logic [3:0]  loop_count;
  } evt_item_t;

  // Queue entry between parser and output stage (ticks are computed later)
  typedef struct packed {
    logic [1:0]  kind;
    logic        chip_select;
    logic [7:0]  reg_addr;
    logic [7:0]  reg_data;
    logic [15:0] wait_samples;
    logic        fade_request;
    logic [3:0]  loop_count;
  } act_item_t;

  // Configuration registers as seen by the submodules
  typedef struct packed {
    logic       loop_present;
    logic [3:0] max_loops;
    logic [9:0] ticks_per_sample;
  } cfg_t;

  // Input op codes
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_WAIT    = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;
  localparam logic [1:0] KIND_RESTART = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_PRESENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOOPS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS        = 2'd2;

  // Reset values of the configuration registers
  localparam logic       RST_LOOP_PRESENT = 1'b0;
  localparam logic [3:0] RST_MAX_LOOPS    = 4'd2;
  localparam logic [9:0] RST_TICKS        = 10'd612;

  // Command bytes
  localparam logic [7:0] CMD_WR_CHIP0   = 8'h55;
  localparam logic [7:0] CMD_WR_CHIP1   = 8'hA5;
  localparam logic [7:0] CMD_WR_CHIP1_B = 8'hA0;
  localparam logic [7:0] CMD_SKIP2_A    = 8'h54;
  localparam logic [7:0] CMD_SKIP2_B    = 8'hA4;
  localparam logic [7:0] CMD_SKIP2_C    = 8'h5A;
  localparam logic [7:0] CMD_SKIP1_A    = 8'h30;
  localparam logic [7:0] CMD_SKIP1_B    = 8'h50;
  localparam logic [7:0] CMD_WAIT_N     = 8'h61;
  localparam logic [7:0] CMD_WAIT_735   = 8'h62;
  localparam logic [7:0] CMD_WAIT_882   = 8'h63;
  localparam logic [7:0] CMD_END        = 8'h66;
  localparam logic [3:0] CMD_SHORT_HI   = 4'h7;

  // Wait amounts of the fixed wait commands
  localparam logic signed [18:0] WAIT_735 = 19'sd735;
  localparam logic signed [18:0] WAIT_882 = 19'sd882;

  // Sample credit bounds
  localparam logic signed [18:0] CREDIT_MIN = -19'sd131072;
  localparam logic signed [18:0] CREDIT_MAX = 19'sd131071;
  localparam logic signed [18:0] WAIT_CAP   = 19'sd65535;

  localparam logic [3:0] LOOPS_SAT = 4'd15;

  // Parse phases
  typedef enum logic [2:0] {
    PH_CMD = 3'b001,
    PH_OP1 = 3'b010,
    PH_OP2 = 3'b100
  } phase_t;

  // Queue between parser and output stage
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

endpackage

// File: rtl/vgm_command_stream_parser.sv
// Top level of the VGM command stream parser: configuration registers and
// the front end, queue and output stage. Depends on vgmcsp_pkg and submodules.
//
//  channel  direction  handshake              payload
//  cmd      in         cmd_valid / cmd_stall  cmd_item_t (op, stream_byte)
//  evt      out        evt_valid / evt_stall  evt_item_t (kind ... loop_count)
//  cfg      in         cfg_we                 cfg_index, cfg_data
//
// One byte per cycle is accepted while cmd_stall is low; parse state and credit
// update in that cycle. A result passes through a two-entry queue and then the
// output register, which also applies the tick multiply.
// cmd_stall rises only while the queue is full, i.e. when evt has been stalled.
// Synchronous reset rst clears parse state, queue and output valid; no
// clearing pass is needed.
module vgm_command_stream_parser (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  vgmcsp_pkg::cmd_item_t               cmd,
  output logic                                evt_valid,
  input  logic                                evt_stall,
  output vgmcsp_pkg::evt_item_t               evt,
  input  logic                                cfg_we,
  input  logic [vgmcsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vgmcsp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import vgmcsp_pkg::*;

  cfg_t      cfg;
  logic      take;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_nonempty;
  act_item_t act_in;
  act_item_t act_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.loop_present     <= RST_LOOP_PRESENT;
      cfg.max_loops        <= RST_MAX_LOOPS;
      cfg.ticks_per_sample <= RST_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOOP_PRESENT: cfg.loop_present     <= cfg_data[0];
        CFG_MAX_LOOPS:    cfg.max_loops        <= cfg_data[3:0];
        CFG_TICKS:        cfg.ticks_per_sample <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cmd_stall = q_full;
  assign take      = cmd_valid && !cmd_stall;

  vgmcsp_front u_front (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .take (take),
    .cmd  (cmd),
    .push (push),
    .act  (act_in)
  );

  vgmcsp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (act_in),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .rdata    (act_out)
  );

  vgmcsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .nonempty  (q_nonempty),
    .act       (act_out),
    .pop       (pop),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt)
  );

endmodule

// File: rtl/vgmcsp_front.sv
// Parser front end: accepts stream bytes, tracks parse phase, credit and loops,
// and pushes one action per result into the queue. Depends on vgmcsp_pkg.
module vgmcsp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  vgmcsp_pkg::cfg_t      cfg,
  input  logic                  take,
  input  vgmcsp_pkg::cmd_item_t cmd,
  output logic                  push,
  output vgmcsp_pkg::act_item_t act
);
  import vgmcsp_pkg::*;

  phase_t             phase, phase_next;
  logic [7:0]         held, held_next;
  logic [7:0]         first, first_next;
  logic signed [17:0] credit, credit_next;
  logic [3:0]         loops, loops_next;

  logic               add_en;
  logic               flush_en;
  logic               emit_en;
  logic signed [18:0] delta;
  logic signed [18:0] sum;
  logic signed [18:0] sum_sat;
  logic [7:0]         b;

  assign b = cmd.stream_byte;

  // Classify the byte against the current parse phase
  always_comb begin
    phase_next = phase;
    held_next  = held;
    first_next = first;
    loops_next = loops;
    add_en     = 1'b0;
    flush_en   = 1'b0;
    emit_en    = 1'b0;
    delta      = '0;
    act        = '0;
    case (phase)
      PH_CMD: begin
        held_next = b;
        if (b inside {CMD_WR_CHIP0, CMD_WR_CHIP1, CMD_WR_CHIP1_B, CMD_SKIP2_A,
                      CMD_SKIP2_B, CMD_SKIP2_C, CMD_WAIT_N, CMD_SKIP1_A,
                      CMD_SKIP1_B}) begin
          phase_next = PH_OP1;
        end else if (b == CMD_WAIT_735) begin
          add_en   = 1'b1;
          flush_en = 1'b1;
          delta    = WAIT_735;
        end else if (b == CMD_WAIT_882) begin
          add_en   = 1'b1;
          flush_en = 1'b1;
          delta    = WAIT_882;
        end else if (b == CMD_END) begin
          emit_en = 1'b1;
          if (cfg.loop_present) begin
            loops_next       = (loops == LOOPS_SAT) ? LOOPS_SAT : loops + 4'd1;
            act.kind         = KIND_RESTART;
            act.fade_request = (loops_next == cfg.max_loops);
          end else begin
            act.kind = KIND_END;
          end
        end else if (b[7:4] == CMD_SHORT_HI) begin
          add_en   = 1'b1;
          flush_en = 1'b1;
          delta    = 19'(b[3:0]) + 19'sd1;
        end
      end
      PH_OP1: begin
        if (held inside {CMD_SKIP1_A, CMD_SKIP1_B}) begin
          phase_next = PH_CMD;
        end else begin
          first_next = b;
          phase_next = PH_OP2;
        end
      end
      PH_OP2: begin
        phase_next = PH_CMD;
        if (held inside {CMD_WR_CHIP0, CMD_WR_CHIP1, CMD_WR_CHIP1_B}) begin
          add_en          = 1'b1;
          delta           = -19'sd1;
          emit_en         = 1'b1;
          act.kind        = KIND_WRITE;
          act.chip_select = (held != CMD_WR_CHIP0);
          act.reg_addr    = first;
          act.reg_data    = b;
        end else if (held == CMD_WAIT_N) begin
          add_en   = 1'b1;
          flush_en = 1'b1;
          delta    = 19'({b, first});
        end
      end
      default: begin
        phase_next = PH_CMD;
      end
    endcase

    // Saturating credit update
    sum = {credit[17], credit} + delta;
    if (sum < CREDIT_MIN) begin
      sum_sat = CREDIT_MIN;
    end else if (sum > CREDIT_MAX) begin
      sum_sat = CREDIT_MAX;
    end else begin
      sum_sat = sum;
    end
    credit_next = add_en ? sum_sat[17:0] : credit;

    // Positive credit goes out as a wait and is cleared
    if (flush_en && (sum_sat > 19'sd0)) begin
      emit_en          = 1'b1;
      act.kind         = KIND_WAIT;
      act.wait_samples = (sum_sat > WAIT_CAP) ? 16'hFFFF : sum_sat[15:0];
      credit_next      = '0;
    end

    act.loop_count = loops_next;
  end

  assign push = take && (cmd.op == OP_BYTE) && emit_en;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_CMD;
      held   <= '0;
      first  <= '0;
      credit <= '0;
      loops  <= '0;
    end else if (take) begin
      if (cmd.op == OP_START) begin
        phase  <= PH_CMD;
        held   <= '0;
        first  <= '0;
        credit <= '0;
        loops  <= '0;
      end else begin
        phase  <= phase_next;
        held   <= held_next;
        first  <= first_next;
        credit <= credit_next;
        loops  <= loops_next;
      end
    end
  end

endmodule

// File: rtl/vgmcsp_queue.sv
// Short register queue between parser front end and output stage.
// Depends on vgmcsp_pkg (entry type and depth).
module vgmcsp_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  vgmcsp_pkg::act_item_t wdata,
  input  logic                  pop,
  output logic                  full,
  output logic                  nonempty,
  output vgmcsp_pkg::act_item_t rdata
);
  import vgmcsp_pkg::*;

  act_item_t         slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign nonempty = (count != '0);
  assign rdata    = slots[rptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

// File: rtl/vgmcsp_back.sv
// Output stage: pops actions, scales waits to timer ticks and holds the
// result register for the output channel. Depends on vgmcsp_pkg.
module vgmcsp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  vgmcsp_pkg::cfg_t      cfg,
  input  logic                  nonempty,
  input  vgmcsp_pkg::act_item_t act,
  output logic                  pop,
  output logic                  evt_valid,
  input  logic                  evt_stall,
  output vgmcsp_pkg::evt_item_t evt
);
  import vgmcsp_pkg::*;

  // Load a new result when the register is empty or being taken
  assign pop = nonempty && (!evt_valid || !evt_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (pop) begin
      evt_valid <= 1'b1;
    end else if (!evt_stall) begin
      evt_valid <= 1'b0;
    end
  end

  // Result payload; 16 x 10 multiply for the tick count
  always_ff @(posedge clk) begin
    if (pop) begin
      evt.kind         <= act.kind;
      evt.chip_select  <= act.chip_select;
      evt.reg_addr     <= act.reg_addr;
      evt.reg_data     <= act.reg_data;
      evt.wait_samples <= act.wait_samples;
      evt.wait_ticks   <= 26'(act.wait_samples) * 26'(cfg.ticks_per_sample);
      evt.fade_request <= act.fade_request;
      evt.loop_count   <= act.loop_count;
    end
  end

`ifndef SYNTHESIS
  a_wait_nonzero: assert property (@(posedge clk) disable iff (rst)
    evt_valid && (evt.kind == KIND_WAIT) |-> evt.wait_samples != '0)
    else $error("wait result with zero samples");
`endif

endmodule

// File: verif/testbench.sv
// Self-checking testbench for vgm_command_stream_parser: drives command bytes
// with bursty timing, predicts events in a scoreboard class and compares them.
// Depends on vgmcsp_pkg and the RTL under rtl/.
module testbench;
  import vgmcsp_pkg::*;

  // Event predictor and checker: tracks parse state, sample credit and loops
  class vgm_event_checker;
    logic        loop_on;
    logic [3:0]  loop_limit;
    logic [9:0]  tick_scale;
    phase_t      parse_ph;
    logic [7:0]  held_cmd;
    logic [7:0]  first_op;
    int          credit;
    logic [3:0]  loops;
    evt_item_t   pending_events[$];
    int          errors;

    function new();
      loop_on    = RST_LOOP_PRESENT;
      loop_limit = RST_MAX_LOOPS;
      tick_scale = RST_TICKS;
      errors     = 0;
      clear_track();
    endfunction

    function void clear_track();
      parse_ph = PH_CMD;
      held_cmd = '0;
      first_op = '0;
      credit   = 0;
      loops    = '0;
    endfunction

    function void set_config(logic lp, logic [3:0] ml, logic [9:0] tps);
      loop_on    = lp;
      loop_limit = ml;
      tick_scale = tps;
    endfunction

    function int pending();
      return pending_events.size();
    endfunction

    // Blank event of one kind, loop count attached
    function evt_item_t blank_event(logic [1:0] kind);
      evt_item_t e;
      e = '0;
      e.kind = kind;
      e.loop_count = loops;
      return e;
    endfunction

    function void add_credit(int d);
      int v;
      v = credit + d;
      if (v < int'(CREDIT_MIN)) v = int'(CREDIT_MIN);
      if (v > int'(CREDIT_MAX)) v = int'(CREDIT_MAX);
      credit = v;
    endfunction

    // Positive credit goes out as one wait, capped at 16 bits
    function void flush_wait();
      int n;
      evt_item_t e;
      if (credit <= 0) return;
      n = (credit > int'(WAIT_CAP)) ? int'(WAIT_CAP) : credit;
      credit = 0;
      e = blank_event(KIND_WAIT);
      e.wait_samples = n[15:0];
      e.wait_ticks = 26'(n * int'(tick_scale));
      pending_events.push_back(e);
    endfunction

    function void write_event(logic chip, logic [7:0] data);
      evt_item_t e;
      add_credit(-1);
      e = blank_event(KIND_WRITE);
      e.chip_select = chip;
      e.reg_addr = first_op;
      e.reg_data = data;
      pending_events.push_back(e);
    endfunction

    function void end_of_track();
      evt_item_t e;
      if (!loop_on) begin
        pending_events.push_back(blank_event(KIND_END));
        return;
      end
      if (loops < LOOPS_SAT) loops++;
      e = blank_event(KIND_RESTART);
      e.fade_request = (loops == loop_limit);
      pending_events.push_back(e);
    endfunction

    // One accepted item: update state, queue any event it causes
    function void take_byte(cmd_item_t it);
      logic [7:0] b;
      b = it.stream_byte;
      if (it.op == OP_START) begin
        clear_track();
        return;
      end
      case (parse_ph)
        PH_CMD: begin
          held_cmd = b;
          case (b)
            CMD_WR_CHIP0, CMD_WR_CHIP1, CMD_WR_CHIP1_B,
            CMD_SKIP2_A, CMD_SKIP2_B, CMD_SKIP2_C,
            CMD_WAIT_N, CMD_SKIP1_A, CMD_SKIP1_B: parse_ph = PH_OP1;
            CMD_WAIT_735: begin
              add_credit(int'(WAIT_735));
              flush_wait();
            end
            CMD_WAIT_882: begin
              add_credit(int'(WAIT_882));
              flush_wait();
            end
            CMD_END: end_of_track();
            default: begin
              if (b[7:4] == CMD_SHORT_HI) begin
                add_credit(int'(b[3:0]) + 1);
                flush_wait();
              end
            end
          endcase
        end
        PH_OP1: begin
          if (held_cmd == CMD_SKIP1_A || held_cmd == CMD_SKIP1_B) begin
            parse_ph = PH_CMD;
          end else begin
            first_op = b;
            parse_ph = PH_OP2;
          end
        end
        default: begin
          parse_ph = PH_CMD;
          case (held_cmd)
            CMD_WR_CHIP0: write_event(1'b0, b);
            CMD_WR_CHIP1, CMD_WR_CHIP1_B: write_event(1'b1, b);
            CMD_WAIT_N: begin
              add_credit(int'({b, first_op}));
              flush_wait();
            end
            default: ;
          endcase
        end
      endcase
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_field(string name, logic [25:0] got, logic [25:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // One accepted event against the oldest prediction
    task match_event(evt_item_t got);
      evt_item_t want;
      if (pending_events.size() == 0) begin
        report($sformatf("event with nothing predicted: %p", got));
        return;
      end
      want = pending_events.pop_front();
      check_field("kind", 26'(got.kind), 26'(want.kind));
      check_field("chip_select", 26'(got.chip_select), 26'(want.chip_select));
      check_field("reg_addr", 26'(got.reg_addr), 26'(want.reg_addr));
      check_field("reg_data", 26'(got.reg_data), 26'(want.reg_data));
      check_field("wait_samples", 26'(got.wait_samples), 26'(want.wait_samples));
      check_field("wait_ticks", got.wait_ticks, want.wait_ticks);
      check_field("fade_request", 26'(got.fade_request), 26'(want.fade_request));
      check_field("loop_count", 26'(got.loop_count), 26'(want.loop_count));
    endtask
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_stall;
  cmd_item_t             cmd_in = '0;
  logic                  evt_valid;
  logic                  evt_stall = 1'b0;
  evt_item_t             evt_out;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  vgm_event_checker sb;
  int burst_left = 0;
  int items_sent = 0;
  int stall_cycle = 0;
  int stall_mode = 0;

  // Loop present, max loops, ticks per sample for each random phase
  int cfg_plan[7][3] = '{'{1, 1, 1}, '{1, 15, 1023}, '{0, 8, 1023}, '{1, 0, 0},
                         '{1, 3, 17}, '{0, 1, 0}, '{1, 2, 612}};

  vgm_command_stream_parser DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd_in),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Everything changes at posedge, so mid-cycle values are what the edge sees
  always @(negedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) sb.take_byte(cmd_in);
      if (evt_valid && !evt_stall) sb.match_event(evt_out);
    end
  end

  // Receiver back-pressure in one of four randomly chosen stall modes
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 256 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: evt_stall <= 1'b0;
      1: evt_stall <= ($urandom_range(0, 3) == 0);
      2: evt_stall <= ($urandom_range(0, 3) != 0);
      default: evt_stall <= (stall_cycle % 8 < 3);
    endcase
  end

  // Send one item; bursts of random length, random gaps between them
  task automatic send_item(input logic op, input logic [7:0] b);
    bit taken;
    int gap;
    cmd_item_t it;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    it.op = op;
    it.stream_byte = b;
    cmd_in <= it;
    cmd_valid <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !cmd_stall;
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OP_BYTE, b);
  endtask

  // Drain all events, let the pipe settle, then write all three registers
  task automatic reconfigure(input int lp, input int ml, input int tps);
    cmd_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LOOP_PRESENT;
    cfg_data <= CFG_DATA_W'(lp);
    @(posedge clk);
    cfg_index <= CFG_MAX_LOOPS;
    cfg_data <= CFG_DATA_W'(ml);
    @(posedge clk);
    cfg_index <= CFG_TICKS;
    cfg_data <= CFG_DATA_W'(tps);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(lp[0], ml[3:0], tps[9:0]);
  endtask

  // One well-formed command with random content, or noise
  task automatic send_random_sequence();
    int pick;
    int unsigned n;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      case ($urandom_range(0, 2))
        0: c = CMD_WR_CHIP0;
        1: c = CMD_WR_CHIP1;
        default: c = CMD_WR_CHIP1_B;
      endcase
      send_byte(c);
      send_byte(8'($urandom));
      send_byte(8'($urandom));
    end else if (pick < 44) begin
      send_byte({CMD_SHORT_HI, 4'($urandom)});
    end else if (pick < 50) begin
      send_byte($urandom_range(0, 1) ? CMD_WAIT_735 : CMD_WAIT_882);
    end else if (pick < 58) begin
      n = $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom_range(0, 65535);
      send_byte(CMD_WAIT_N);
      send_byte(n[7:0]);
      send_byte(n[15:8]);
    end else if (pick < 65) begin
      case ($urandom_range(0, 2))
        0: c = CMD_SKIP2_A;
        1: c = CMD_SKIP2_B;
        default: c = CMD_SKIP2_C;
      endcase
      send_byte(c);
      send_byte(8'($urandom));
      send_byte(8'($urandom));
    end else if (pick < 70) begin
      send_byte($urandom_range(0, 1) ? CMD_SKIP1_A : CMD_SKIP1_B);
      send_byte(8'($urandom));
    end else if (pick < 78) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 18) : 1;
      repeat (n) send_byte(CMD_END);
    end else if (pick < 81) begin
      send_item(OP_START, 8'($urandom));
    end else begin
      // noise: any byte, may open a command that the next sequence cuts into
      send_byte(8'($urandom));
    end
  endtask

  initial begin
    int start;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every command, operand extremes, reset configuration
    send_byte(CMD_WR_CHIP0);   send_byte(8'h00); send_byte(8'h00);
    send_byte(CMD_WR_CHIP1);   send_byte(8'hFF); send_byte(8'hFF);
    send_byte(CMD_WR_CHIP1_B); send_byte(8'h5A); send_byte(8'hA5);
    send_byte(8'h72);          // credit back to zero after writes: no wait
    send_byte(8'h7F);
    send_byte(CMD_WAIT_735);
    send_byte(CMD_WAIT_882);
    send_byte(CMD_WAIT_N);     send_byte(8'hFF); send_byte(8'hFF);
    send_byte(CMD_SKIP2_A);    send_byte(CMD_WR_CHIP0); send_byte(CMD_END);
    send_byte(CMD_SKIP2_B);    send_byte(CMD_END); send_byte(CMD_WAIT_735);
    send_byte(CMD_SKIP2_C);    send_byte(8'h00); send_byte(8'hFF);
    send_byte(CMD_SKIP1_A);    send_byte(CMD_END);
    send_byte(CMD_SKIP1_B);    send_byte(CMD_WR_CHIP1);
    send_byte(8'hFF);          // unknown command
    send_byte(CMD_END);        // track end, loop disabled
    send_item(OP_START, 8'hFF);

    // Random phases over several register settings
    foreach (cfg_plan[i]) begin
      reconfigure(cfg_plan[i][0], cfg_plan[i][1], cfg_plan[i][2]);
      if (cfg_plan[i][0] == 1) begin
        // run the loop count past its saturation point
        send_item(OP_START, 8'h00);
        repeat (17) send_byte(CMD_END);
      end
      start = items_sent;
      while (items_sent - start < 110) send_random_sequence();
    end

    cmd_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
